// ===== rtl/graph_reachability_with_exclusion_top_defines.svh =====
// assertion macros for the reachability block checker
`ifndef GRAPH_REACHABILITY_WITH_EXCLUSION_TOP_DEFINES_SVH
`define GRAPH_REACHABILITY_WITH_EXCLUSION_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define GRWE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("grwe same-cycle check failed");

// next-cycle implication, sampled on clk, off during reset
`define GRWE_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("grwe next-cycle check failed");

`endif

// ===== rtl/grwe_pkg.sv =====
`default_nettype none

package grwe_pkg;

    localparam int NODE_W = 4;

    typedef enum logic [1:0] {
        MODE_EDGE   = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_MARK   = 2'd2,
        MODE_QUERY  = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t             mode;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
        logic [NODE_W-1:0] node_skip;
        logic              flag;
    } req_t;

    typedef struct packed {
        logic connected;
        logic goal_is_skipped;
    } rsp_t;

    typedef struct packed {
        logic load;
        logic edge_rd;
        logic edge_wr;
        logic mark_wr;
        logic scan_clr;
        logic scan;
        logic q_short;
        logic q_init;
        logic q_eval;
    } cmd_t;

    typedef struct packed {
        mode_t mode;
        logic  a_ok;
        logic  edge_ok;
        logic  q_short;
        logic  row_last;
        logic  round_last;
        logic  found;
        logic  next_empty;
    } status_t;

endpackage

`default_nettype wire

// ===== rtl/graph_reachability_with_exclusion_top.sv =====
// mark, settled query: dispatch, done; edge write: read then write a row; removal: scan, drain
// query walk: up to NODES rounds of scan, drain, eval; one memory row read per scan cycle
// done pulses in the last busy cycle with the result; receiver cannot stall
// next request is taken the cycle after done, so requests never overlap
// reset: async active-low rst_n clears row valid bits, deleted marks, walk sets and controller
`default_nettype none

module graph_reachability_with_exclusion_top
    import grwe_pkg::*;
#(
    parameter int NODES = 16
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire req_t req,
    output logic      busy,
    output logic      done,
    output rsp_t      result
);

    cmd_t    cmd;
    status_t st;

    grwe_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .st    (st),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    grwe_datapath #(
        .NODES (NODES)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .cmd    (cmd),
        .st     (st),
        .result (result)
    );

endmodule

`default_nettype wire

// ===== rtl/grwe_ctrl.sv =====
`default_nettype none

module grwe_ctrl
    import grwe_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    input  wire status_t st,
    output cmd_t         cmd,
    output logic         busy,
    output logic         done
);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_DISPATCH = 8'b0000_0010,
        S_EDGE_RD  = 8'b0000_0100,
        S_EDGE_WR  = 8'b0000_1000,
        S_SCAN     = 8'b0001_0000,
        S_DRAIN    = 8'b0010_0000,
        S_EVAL     = 8'b0100_0000,
        S_DONE     = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (st.mode)
                    MODE_EDGE:
                    begin
                        state_next = st.edge_ok ? S_EDGE_RD : S_DONE;
                    end
                    MODE_REMOVE:
                    begin
                        if (st.a_ok)
                        begin
                            cmd.scan_clr = 1'b1;
                            state_next   = S_SCAN;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                    MODE_MARK:
                    begin
                        cmd.mark_wr = 1'b1;
                        state_next  = S_DONE;
                    end
                    MODE_QUERY:
                    begin
                        if (st.q_short)
                        begin
                            cmd.q_short = 1'b1;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            cmd.q_init = 1'b1;
                            state_next = S_SCAN;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_EDGE_RD:
            begin
                cmd.edge_rd = 1'b1;
                state_next  = S_EDGE_WR;
            end
            S_EDGE_WR:
            begin
                cmd.edge_wr = 1'b1;
                state_next  = S_DONE;
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (st.row_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = (st.mode == MODE_QUERY) ? S_EVAL : S_DONE;
            end
            S_EVAL:
            begin
                cmd.q_eval = 1'b1;
                if (st.found || st.next_empty || st.round_last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

endmodule

`default_nettype wire

// ===== rtl/grwe_datapath.sv =====
`default_nettype none

module grwe_datapath
    import grwe_pkg::*;
#(
    parameter int NODES = 16
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire req_t req,
    input  wire cmd_t cmd,
    output status_t   st,
    output rsp_t      result
);

    localparam int ROW_W = $clog2(NODES);
    localparam int EXT_W = ROW_W + NODE_W;
    localparam logic [EXT_W-1:0] NODES_X   = EXT_W'(NODES);
    localparam logic [ROW_W-1:0] ROW_LAST  = ROW_W'(NODES - 1);
    localparam logic [NODES-1:0] ONE_BIT   = {{(NODES-1){1'b0}}, 1'b1};

    // row memory, valid bit per row stands for the cleared reset value
    logic [NODES-1:0] mem [NODES];
    logic [NODES-1:0] mem_q_reg;
    logic             mem_qv_reg;
    logic             mem_qv_next;

    logic [NODES-1:0] row_valid_reg;
    logic [NODES-1:0] row_valid_next;

    req_t             req_reg;
    req_t             req_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    logic [ROW_W-1:0] round_reg;
    logic [ROW_W-1:0] round_next;
    logic [ROW_W-1:0] rd_row_reg;
    logic [ROW_W-1:0] rd_row_next;
    logic             rd_pend_reg;
    logic             rd_pend_next;
    logic [NODES-1:0] deleted_reg;
    logic [NODES-1:0] deleted_next;
    logic [NODES-1:0] visited_reg;
    logic [NODES-1:0] visited_next;
    logic [NODES-1:0] frontier_reg;
    logic [NODES-1:0] frontier_next;
    logic [NODES-1:0] acc_reg;
    logic [NODES-1:0] acc_next;
    logic             conn_reg;
    logic             conn_next;
    logic             gskip_reg;
    logic             gskip_next;

    logic [EXT_W-1:0] a_ext;
    logic [EXT_W-1:0] b_ext;
    logic [EXT_W-1:0] s_ext;
    logic [ROW_W-1:0] a_row;
    logic             a_ok;
    logic             b_ok;
    logic             s_ok;
    logic [NODES-1:0] bit_a;
    logic [NODES-1:0] bit_b;
    logic [NODES-1:0] bit_s;
    logic             start_del;
    logic             short_val;
    logic [NODES-1:0] row_eff;
    logic [NODES-1:0] next_set;
    logic             take;

    logic             rd_en;
    logic [ROW_W-1:0] rd_addr;
    logic             wr_en;
    logic [ROW_W-1:0] wr_addr;
    logic [NODES-1:0] wr_data;

    always_comb
    begin
        a_ext     = EXT_W'(req_reg.node_a);
        b_ext     = EXT_W'(req_reg.node_b);
        s_ext     = EXT_W'(req_reg.node_skip);
        a_row     = a_ext[ROW_W-1:0];
        a_ok      = (a_ext < NODES_X);
        b_ok      = (b_ext < NODES_X);
        s_ok      = (s_ext < NODES_X);
        bit_a     = a_ok ? (ONE_BIT << req_reg.node_a) : '0;
        bit_b     = b_ok ? (ONE_BIT << req_reg.node_b) : '0;
        bit_s     = s_ok ? (ONE_BIT << req_reg.node_skip) : '0;
        start_del = |(deleted_reg & bit_a);
        short_val = a_ok && b_ok && (req_reg.node_a != req_reg.node_skip) && !start_del
                    && (req_reg.node_a == req_reg.node_b);
        row_eff   = mem_qv_reg ? mem_q_reg : '0;
        next_set  = acc_reg & ~visited_reg;
        take      = rd_pend_reg;
    end

    always_comb
    begin
        st.mode       = req_reg.mode;
        st.a_ok       = a_ok;
        st.edge_ok    = a_ok && b_ok;
        st.q_short    = !a_ok || !b_ok || (req_reg.node_a == req_reg.node_skip)
                        || start_del || (req_reg.node_a == req_reg.node_b);
        st.row_last   = (row_reg == ROW_LAST);
        st.round_last = (round_reg == ROW_LAST);
        st.found      = |(next_set & bit_b);
        st.next_empty = ~|next_set;
    end

    // memory port control
    always_comb
    begin
        rd_en   = cmd.edge_rd || cmd.scan;
        rd_addr = cmd.edge_rd ? a_row : row_reg;
        wr_en   = 1'b0;
        wr_addr = a_row;
        wr_data = '0;
        if (cmd.edge_wr)
        begin
            wr_en   = 1'b1;
            wr_data = req_reg.flag ? (row_eff | bit_b) : (row_eff & ~bit_b);
        end
        else if (take && (req_reg.mode == MODE_REMOVE))
        begin
            wr_en   = 1'b1;
            wr_addr = rd_row_reg;
            wr_data = (rd_row_reg == a_row) ? '0 : (row_eff & ~bit_a);
        end
    end

    always_comb
    begin
        req_next       = req_reg;
        row_next       = row_reg;
        round_next     = round_reg;
        rd_row_next    = rd_row_reg;
        rd_pend_next   = cmd.scan;
        mem_qv_next    = mem_qv_reg;
        row_valid_next = row_valid_reg;
        deleted_next   = deleted_reg;
        visited_next   = visited_reg;
        frontier_next  = frontier_reg;
        acc_next       = acc_reg;
        conn_next      = conn_reg;
        gskip_next     = gskip_reg;

        if (cmd.load)
        begin
            req_next   = req;
            conn_next  = 1'b0;
            gskip_next = (req.mode == MODE_QUERY) && (req.node_b == req.node_skip);
        end
        if (rd_en)
        begin
            mem_qv_next = row_valid_reg[rd_addr];
        end
        if (wr_en)
        begin
            row_valid_next[wr_addr] = 1'b1;
        end
        if (cmd.mark_wr)
        begin
            deleted_next = req_reg.flag ? (deleted_reg | bit_a) : (deleted_reg & ~bit_a);
        end
        if (cmd.scan_clr)
        begin
            row_next = '0;
        end
        if (cmd.q_short)
        begin
            conn_next = short_val;
        end
        if (cmd.q_init)
        begin
            visited_next  = bit_s | deleted_reg | bit_a;
            frontier_next = bit_a;
            acc_next      = '0;
            row_next      = '0;
            round_next    = '0;
        end
        if (cmd.scan)
        begin
            row_next    = row_reg + ROW_W'(1);
            rd_row_next = row_reg;
        end
        if (take && (req_reg.mode == MODE_QUERY) && frontier_reg[rd_row_reg])
        begin
            acc_next = acc_reg | row_eff;
        end
        if (cmd.q_eval)
        begin
            conn_next     = |(next_set & bit_b);
            visited_next  = visited_reg | next_set;
            frontier_next = next_set;
            acc_next      = '0;
            row_next      = '0;
            round_next    = round_reg + ROW_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg       <= '0;
            round_reg     <= '0;
            rd_pend_reg   <= 1'b0;
            row_valid_reg <= '0;
            deleted_reg   <= '0;
            visited_reg   <= '0;
            frontier_reg  <= '0;
        end
        else
        begin
            row_reg       <= row_next;
            round_reg     <= round_next;
            rd_pend_reg   <= rd_pend_next;
            row_valid_reg <= row_valid_next;
            deleted_reg   <= deleted_next;
            visited_reg   <= visited_next;
            frontier_reg  <= frontier_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        rd_row_reg <= rd_row_next;
        mem_qv_reg <= mem_qv_next;
        acc_reg    <= acc_next;
        conn_reg   <= conn_next;
        gskip_reg  <= gskip_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            mem_q_reg <= mem[rd_addr];
        end
    end

    assign result.connected       = conn_reg;
    assign result.goal_is_skipped = gskip_reg;

endmodule

`default_nettype wire

// ===== rtl/grwe_checker.sv =====
`default_nettype none
`include "graph_reachability_with_exclusion_top_defines.svh"

module grwe_checker
    import grwe_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic done,
    input wire rsp_t result
);

    // an accepted request always makes the block busy
    `GRWE_ASSERT_NXT(a_accept_busy, start && !busy, busy)
    // a result only appears while a request is in flight
    `GRWE_ASSERT_IMP(a_done_busy, done, busy)
    // a result ends the request, so the block is free right after
    `GRWE_ASSERT_NXT(a_done_frees, done, !busy && !done)
    // busy drops only after its result was shown
    `GRWE_ASSERT_IMP(a_fall_after_done, $fell(busy), $past(done))
    // a skipped goal is never reported as connected
    `GRWE_ASSERT_IMP(a_skip_excl, done && result.goal_is_skipped, !result.connected)

endmodule

bind graph_reachability_with_exclusion_top grwe_checker u_grwe_checker (.*);

`default_nettype wire
